### rtl/core/gasf_pkg.sv
// Shared types and constants for the global alignment score fill block.
// Holds request and status codes, register indexes, reset values and the
// cell command group. No dependencies.
`timescale 1ns / 1ps

package gasf_pkg;

    // Default sizing
    localparam int MAX_REF_DEF    = 64;
    localparam int MAX_QUERY_DEF  = 1024;
    localparam int SCORE_BITS_DEF = 16;

    // Fixed field widths
    localparam int SYM_W   = 8;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int MATCH_W = 4;
    localparam int PEN_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Request kinds (carried on tuser)
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

    // Register reset values
    localparam logic [MATCH_W-1:0] MATCH_RST    = 4'd3;
    localparam logic [PEN_W-1:0]   MISMATCH_RST = 5'h1F;  // -1
    localparam logic [PEN_W-1:0]   GAP_RST      = 5'h1E;  // -2

    // Scoring registers; penalties are two's complement
    typedef struct packed {
        logic [MATCH_W-1:0] match;
        logic [PEN_W-1:0]   mismatch;
        logic [PEN_W-1:0]   gap;
    } t_cfg;

    // Broadcast command to every cell of the row
    typedef struct packed {
        logic             load;    // reload the boundary row
        logic             wr_en;   // store a reference symbol at the current length
        logic [SYM_W-1:0] wr_sym;
    } t_cell_cmd;

endpackage

### rtl/core/gasf_gap_mul.sv
// Saturated product of a small unsigned count and the signed gap score.
// Used for boundary cells. Depends on gasf_pkg.
`timescale 1ns / 1ps

module gasf_gap_mul #(
    parameter int K_BITS     = 7,
    parameter int SCORE_BITS = gasf_pkg::SCORE_BITS_DEF
) (
    input  logic [K_BITS-1:0]            i_k,
    input  logic [gasf_pkg::PEN_W-1:0]   i_gap,
    output logic [SCORE_BITS-1:0]        o_score
);

    localparam int PW = K_BITS + gasf_pkg::PEN_W + 1;
    localparam int WW = ((PW > SCORE_BITS) ? PW : SCORE_BITS) + 1;
    localparam logic signed [WW-1:0] SMAX =
        signed'({{(WW-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}});
    localparam logic signed [WW-1:0] SMIN = ~SMAX;

    logic signed [PW-1:0] w_k_ext;
    logic signed [PW-1:0] w_gap_ext;
    logic signed [PW-1:0] w_prod;
    logic signed [WW-1:0] w_wide;

    assign w_k_ext   = PW'($signed({1'b0, i_k}));
    assign w_gap_ext = PW'($signed(i_gap));
    assign w_prod    = w_k_ext * w_gap_ext;
    assign w_wide    = WW'(w_prod);

    always_comb begin
        if (w_wide > SMAX) begin
            o_score = SMAX[SCORE_BITS-1:0];
        end else if (w_wide < SMIN) begin
            o_score = SMIN[SCORE_BITS-1:0];
        end else begin
            o_score = w_wide[SCORE_BITS-1:0];
        end
    end

endmodule

### rtl/core/gasf_cell.sv
// One column cell of the score row: holds one reference symbol and one row
// score, and passes the row token to its right neighbor each cycle.
// Depends on gasf_pkg and gasf_gap_mul.
`timescale 1ns / 1ps

module gasf_cell #(
    parameter int CELL_IDX   = 1,
    parameter int IDX_BITS   = 7,
    parameter int SCORE_BITS = gasf_pkg::SCORE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gasf_pkg::t_cfg               i_cfg,
    input  gasf_pkg::t_cell_cmd          i_cmd,
    input  logic [IDX_BITS-1:0]          i_len,
    input  logic                         i_vld,
    input  logic [gasf_pkg::SYM_W-1:0]   i_sym,
    input  logic [SCORE_BITS-1:0]        i_left,
    input  logic [SCORE_BITS-1:0]        i_diag,
    output logic                         o_vld,
    output logic [gasf_pkg::SYM_W-1:0]   o_sym,
    output logic [SCORE_BITS-1:0]        o_left,
    output logic [SCORE_BITS-1:0]        o_diag
);

    localparam int CW = SCORE_BITS + 2;
    localparam logic [IDX_BITS-1:0] MY_IDX   = IDX_BITS'(CELL_IDX);
    localparam logic [IDX_BITS-1:0] PREV_IDX = IDX_BITS'(CELL_IDX - 1);
    localparam logic signed [CW-1:0] SMAX =
        signed'({3'b000, {(SCORE_BITS-1){1'b1}}});
    localparam logic signed [CW-1:0] SMIN = ~SMAX;

    logic [gasf_pkg::SYM_W-1:0] r_sym;
    logic [SCORE_BITS-1:0]      r_score;
    logic                       r_vld;
    logic [gasf_pkg::SYM_W-1:0] r_osym;
    logic [SCORE_BITS-1:0]      r_left;
    logic [SCORE_BITS-1:0]      r_diag;

    logic [gasf_pkg::PEN_W-1:0] w_gap_sel;
    logic [SCORE_BITS-1:0]      w_bound;
    logic                       w_active;
    logic signed [CW-1:0]       w_sub;
    logic signed [CW-1:0]       w_gap;
    logic signed [CW-1:0]       w_diag_c;
    logic signed [CW-1:0]       w_up_c;
    logic signed [CW-1:0]       w_left_c;
    logic signed [CW-1:0]       w_best;
    logic [SCORE_BITS-1:0]      w_new;

    // Boundary value of this column; reset uses the reset gap
    assign w_gap_sel = i_rst_n ? i_cfg.gap : gasf_pkg::GAP_RST;

    gasf_gap_mul #(
        .K_BITS     (IDX_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_bound (
        .i_k     (MY_IDX),
        .i_gap   (w_gap_sel),
        .o_score (w_bound)
    );

    assign w_active = (MY_IDX <= i_len);

    always_comb begin
        w_sub    = (r_sym == i_sym) ? CW'($signed({1'b0, i_cfg.match}))
                                    : CW'($signed(i_cfg.mismatch));
        w_gap    = CW'($signed(i_cfg.gap));
        w_diag_c = CW'($signed(i_diag)) + w_sub;
        w_up_c   = CW'($signed(r_score)) + w_gap;
        w_left_c = CW'($signed(i_left)) + w_gap;
        w_best   = w_diag_c;
        if (w_up_c > w_best) begin
            w_best = w_up_c;
        end
        if (w_left_c > w_best) begin
            w_best = w_left_c;
        end
        if (w_best > SMAX) begin
            w_new = SMAX[SCORE_BITS-1:0];
        end else if (w_best < SMIN) begin
            w_new = SMIN[SCORE_BITS-1:0];
        end else begin
            w_new = w_best[SCORE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_score <= w_bound;
        end else begin
            r_vld <= i_vld;
            if (i_cmd.load) begin
                r_score <= w_bound;
            end else if (i_vld && w_active) begin
                r_score <= w_new;
            end
        end
    end

    // Token payload; past the reference end the left value passes unchanged
    always_ff @(posedge i_clk) begin
        r_osym <= i_sym;
        r_left <= w_active ? w_new : i_left;
        r_diag <= r_score;
        if (i_cmd.wr_en && (i_len == PREV_IDX)) begin
            r_sym <= i_cmd.wr_sym;
        end
    end

    assign o_vld  = r_vld;
    assign o_sym  = r_osym;
    assign o_left = r_left;
    assign o_diag = r_diag;

endmodule

### rtl/core/global_alignment_score_fill_top.sv
// Top level of the global alignment score fill block: request decode,
// boundary column, row of gasf_cell instances and result staging.
// Depends on gasf_pkg, gasf_gap_mul and gasf_cell.
`timescale 1ns / 1ps

// Needleman-Wunsch score fill with a linear gap, one table row per query
// item. The reference (up to MAX_REF byte symbols) lives in a row of
// MAX_REF cells, each holding one symbol and its column's score of the
// previous row. A query launches a token at the boundary column that moves
// one cell per clock; no item is accepted until it has walked the full cell
// row, regardless of the reference length. Clear, restart and accepted append
// items reload the boundary row; they, full appends and queries past the limit
// stage their result at once, so those run at one item per cycle while the
// output side keeps up. One result item comes back for every request: status
// (ok, query limit reached, reference full), the last cell of the current
// row (saturated to SCORE_BITS, the alignment score after the final query)
// and the count of rows computed. A result waiting at the output does not
// stop the next item from being taken: a pending stage sits between the core
// and the output register. The user must write scoring registers through
// the plain write port while the block is idle; the block does not enforce it.
module global_alignment_score_fill_top #(
    parameter int MAX_REF    = gasf_pkg::MAX_REF_DEF,
    parameter int MAX_QUERY  = gasf_pkg::MAX_QUERY_DEF,
    parameter int SCORE_BITS = gasf_pkg::SCORE_BITS_DEF,
    localparam int QW        = $clog2(MAX_QUERY + 1),
    localparam int OUT_W     = gasf_pkg::STAT_W + SCORE_BITS + QW,
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [gasf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gasf_pkg::PEN_W-1:0]     i_cfg_data,
    // request stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [gasf_pkg::SYM_W-1:0]     i_s_tdata,   // [7:0] symbol
    input  logic [gasf_pkg::REQ_W-1:0]     i_s_tuser,   // [1:0] req_type
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [OUT_TW-1:0]              o_m_tdata    // status, score, row_index, zero pad
);

    localparam int IDX_BITS = $clog2(MAX_REF + 1);
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_BUSY = 1'b1;

    // Control state
    gasf_pkg::t_cfg            r_cfg;
    logic [IDX_BITS-1:0]       r_len;
    logic [QW-1:0]             r_qc;
    logic [SCORE_BITS-1:0]     r_col0;
    logic [SCORE_BITS-1:0]     r_last;
    logic [0:0]                r_state;
    logic                      r_tok_vld;
    logic                      r_pend_vld;
    logic                      r_out_vld;

    // Payload
    logic [gasf_pkg::SYM_W-1:0] r_tok_sym;
    logic [SCORE_BITS-1:0]      r_tok_left;
    logic [SCORE_BITS-1:0]      r_tok_diag;
    logic [gasf_pkg::STAT_W-1:0] r_pend_status;
    logic [SCORE_BITS-1:0]      r_pend_score;
    logic [QW-1:0]              r_pend_row;
    logic [OUT_TW-1:0]          r_out_data;

    logic                       w_acc;
    logic                       w_pend_move;
    logic                       w_pend_free;
    logic                       w_query_ok;
    logic                       w_append_ok;
    logic                       w_load;
    logic [IDX_BITS-1:0]        n_len;
    logic [QW-1:0]              w_col0_k;
    logic [SCORE_BITS-1:0]      w_col0_new;
    logic [SCORE_BITS-1:0]      w_last_bound;
    logic [gasf_pkg::STAT_W-1:0] w_imm_status;
    gasf_pkg::t_cell_cmd        w_cmd;

    // Token wires along the cell row; index 0 is the launch register
    logic                       w_vld  [0:MAX_REF];
    logic [gasf_pkg::SYM_W-1:0] w_sym  [0:MAX_REF];
    logic [SCORE_BITS-1:0]      w_left [0:MAX_REF];
    logic [SCORE_BITS-1:0]      w_diag [0:MAX_REF];

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    assign w_pend_move = r_pend_vld && (!r_out_vld || i_m_tready);
    assign w_pend_free = !r_pend_vld || w_pend_move;
    assign o_s_tready  = (r_state == ST_IDLE) && w_pend_free;
    assign w_acc       = i_s_tvalid && o_s_tready;

    assign w_query_ok  = (i_s_tuser == gasf_pkg::REQ_QUERY) && (r_qc < QW'(MAX_QUERY));
    assign w_append_ok = (i_s_tuser == gasf_pkg::REQ_APPEND) &&
                         (r_len < IDX_BITS'(MAX_REF));
    assign w_load      = w_acc && ((i_s_tuser == gasf_pkg::REQ_CLEAR) || w_append_ok ||
                                   (i_s_tuser == gasf_pkg::REQ_RESTART));

    always_comb begin
        case (i_s_tuser)
            gasf_pkg::REQ_CLEAR:  n_len = '0;
            gasf_pkg::REQ_APPEND: n_len = w_append_ok ? r_len + 1'b1 : r_len;
            default:              n_len = r_len;
        endcase
    end

    always_comb begin
        if ((i_s_tuser == gasf_pkg::REQ_QUERY) && !w_query_ok) begin
            w_imm_status = gasf_pkg::STAT_LIMIT;
        end else if ((i_s_tuser == gasf_pkg::REQ_APPEND) && !w_append_ok) begin
            w_imm_status = gasf_pkg::STAT_FULL;
        end else begin
            w_imm_status = gasf_pkg::STAT_OK;
        end
    end

    assign w_cmd.load   = w_load;
    assign w_cmd.wr_en  = w_acc && w_append_ok;
    assign w_cmd.wr_sym = i_s_tdata;

    // Boundary cell of the new row: (rows + 1) * gap
    assign w_col0_k = r_qc + 1'b1;

    gasf_gap_mul #(
        .K_BITS     (QW),
        .SCORE_BITS (SCORE_BITS)
    ) u_col0 (
        .i_k     (w_col0_k),
        .i_gap   (r_cfg.gap),
        .o_score (w_col0_new)
    );

    // Last cell of a freshly loaded boundary row: length * gap
    gasf_gap_mul #(
        .K_BITS     (IDX_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_last (
        .i_k     (n_len),
        .i_gap   (r_cfg.gap),
        .o_score (w_last_bound)
    );

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    assign w_vld[0]  = r_tok_vld;
    assign w_sym[0]  = r_tok_sym;
    assign w_left[0] = r_tok_left;
    assign w_diag[0] = r_tok_diag;

    for (genvar g = 1; g <= MAX_REF; g++) begin : g_cell
        gasf_cell #(
            .CELL_IDX   (g),
            .IDX_BITS   (IDX_BITS),
            .SCORE_BITS (SCORE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_cmd   (w_cmd),
            .i_len   (r_len),
            .i_vld   (w_vld[g-1]),
            .i_sym   (w_sym[g-1]),
            .i_left  (w_left[g-1]),
            .i_diag  (w_diag[g-1]),
            .o_vld   (w_vld[g]),
            .o_sym   (w_sym[g]),
            .o_left  (w_left[g]),
            .o_diag  (w_diag[g])
        );
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match    <= gasf_pkg::MATCH_RST;
            r_cfg.mismatch <= gasf_pkg::MISMATCH_RST;
            r_cfg.gap      <= gasf_pkg::GAP_RST;
            r_len          <= '0;
            r_qc           <= '0;
            r_col0         <= '0;
            r_last         <= '0;
            r_state        <= ST_IDLE;
            r_tok_vld      <= 1'b0;
            r_pend_vld     <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            // Register writes; indexes past the list are dropped
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    gasf_pkg::CFG_MATCH:    r_cfg.match    <= i_cfg_data[gasf_pkg::MATCH_W-1:0];
                    gasf_pkg::CFG_MISMATCH: r_cfg.mismatch <= i_cfg_data;
                    gasf_pkg::CFG_GAP:      r_cfg.gap      <= i_cfg_data;
                    default: ;
                endcase
            end

            // Launch the row token only for an accepted query
            r_tok_vld <= w_acc && w_query_ok;

            // Advance the output side; hold a result until it is taken
            r_out_vld  <= w_pend_move || (r_out_vld && !i_m_tready);
            r_pend_vld <= (w_acc && !w_query_ok) || w_vld[MAX_REF] ||
                          (r_pend_vld && !w_pend_move);

            if (w_acc) begin
                if (w_load) begin
                    r_len  <= n_len;
                    r_qc   <= '0;
                    r_col0 <= '0;
                    r_last <= w_last_bound;
                end
                if (w_query_ok) begin
                    // Result comes off the row end
                    r_col0  <= w_col0_new;
                    r_qc    <= w_col0_k;
                    r_state <= ST_BUSY;
                end
            end

            if (w_vld[MAX_REF]) begin
                r_last  <= w_left[MAX_REF];
                r_state <= ST_IDLE;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_tok_sym  <= i_s_tdata;
            r_tok_left <= w_col0_new;
            r_tok_diag <= r_col0;
        end

        if (w_acc && !w_query_ok) begin
            r_pend_status <= w_imm_status;
            r_pend_score  <= w_load ? w_last_bound : r_last;
            r_pend_row    <= w_load ? '0 : r_qc;
        end else if (w_vld[MAX_REF]) begin
            r_pend_status <= gasf_pkg::STAT_OK;
            r_pend_score  <= w_left[MAX_REF];
            r_pend_row    <= r_qc;
        end

        if (w_pend_move) begin
            r_out_data <= OUT_TW'({r_pend_row, r_pend_score, r_pend_status});
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // The row end only delivers a token while a query is in flight
    a_token_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[MAX_REF] |-> (r_state == ST_BUSY))
        else $error("row token emerged while idle");

    // Busy never overlaps with an unsent pending result
    a_busy_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUSY) |-> !r_pend_vld)
        else $error("pending result held while a query is running");

    // Every accepted item either starts a row or stages its result
    a_acc_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_pend_vld || (r_state == ST_BUSY)))
        else $error("accepted item produced no work");

    // Row count and reference length stay in range
    a_counts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qc <= QW'(MAX_QUERY)) && (r_len <= IDX_BITS'(MAX_REF)))
        else $error("row count or reference length out of range");
`endif

endmodule
